@@ hdl/goc_pkg.sv @@
// shared types and constants for the gyro offset calibration block
package goc_pkg;

    localparam int NUM_AXES = 3;
    localparam int RAW_W    = 16;
    localparam int SUM_W    = 32;
    localparam int CNT_W    = 16;
    localparam int RATE_W   = 17;

    // rate = |corr| * 128 / 115, done as |corr| * ceil(2^30 / 115) >> 23
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 23;
    localparam int PROD_W      = RAW_W + RECIP_W;
    localparam longint RecipFull = ((64'sd1 <<< 30) + 64'sd114) / 115;
    localparam logic [RECIP_W-1:0] RATE_RECIP = RECIP_W'(RecipFull);

    // one quotient bit per step over the full sum width
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] CALIB_RESET = CNT_W'(100);

    localparam int APB_AW = 2;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_CALIB = APB_AW'(0);

    typedef logic signed [RAW_W-1:0]  axis_t;
    typedef logic signed [RATE_W-1:0] rate_t;

    typedef enum logic [1:0] {
        MODE_MEAS   = 2'd0,
        MODE_START  = 2'd1,
        MODE_SAMPLE = 2'd2,
        MODE_LOAD   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAS,
        S_PROD,
        S_EXEC,
        S_DIV_INIT,
        S_DIV,
        S_COMMIT,
        S_SHOW,
        S_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic accum;
        logic load;
        logic corr_raw;
        logic corr_off;
        logic prod_en;
        logic div_start;
        logic div_step;
        logic div_commit;
    } lane_ctl_t;

endpackage

@@ hdl/goc_if.sv @@
// word channels for the gyro offset calibration block
interface goc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;

    modport source (output valid, output mode, output raw_x, output raw_y, output raw_z,
                    input ready);
    modport sink   (input valid, input mode, input raw_x, input raw_y, input raw_z,
                    output ready);
endinterface

interface goc_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] corr_x;
    logic signed [15:0] corr_y;
    logic signed [15:0] corr_z;
    logic signed [16:0] rate_x;
    logic signed [16:0] rate_y;
    logic signed [16:0] rate_z;
    logic        calib_done;

    modport source (output valid, output corr_x, output corr_y, output corr_z,
                    output rate_x, output rate_y, output rate_z, output calib_done,
                    input ready);
    modport sink   (input valid, input corr_x, input corr_y, input corr_z,
                    input rate_x, input rate_y, input rate_z, input calib_done,
                    output ready);
endinterface

@@ hdl/gyro_offset_calibrate.sv @@
// Gyro zero-offset calibration with rate conversion. One word enters on samp and one word
// leaves on res; three axis lanes work side by side and a merge stage registers the result.
// A measurement passes MEAS, PROD and OUT; start, offset load and ordinary calibration
// samples pass EXEC, SHOW and OUT; the sample that closes a calibration also passes DIV,
// where the per-lane restoring divider forms one quotient bit per cycle over the 32-bit sum.
// A finished word waits in the output register while the next sample is taken.
// calib_samples lies at byte address 0 of the APB port; a value of 0 acts as 1.
module gyro_offset_calibrate (
    input  logic                            clk,
    input  logic                            rst_n,
    goc_in_if.sink                          samp,
    goc_out_if.source                       res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [goc_pkg::APB_AW-1:0]      paddr,
    input  logic [goc_pkg::APB_DW-1:0]      pwdata,
    output logic [goc_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    goc_pkg::state_t                  state_reg;
    goc_pkg::state_t                  state_next;
    goc_pkg::mode_t                   mode_reg;
    logic                             calib_reg;
    logic                             calib_next;
    logic [goc_pkg::CNT_W-1:0]        count_reg;
    logic [goc_pkg::CNT_W-1:0]        count_next;
    logic                             done_reg;
    logic                             done_next;
    logic [goc_pkg::STEP_W-1:0]       step_reg;
    logic [goc_pkg::STEP_W-1:0]       step_next;
    logic [goc_pkg::CNT_W-1:0]        calib_samples_reg;

    logic                             accept;
    logic                             cfg_write;
    logic [goc_pkg::CNT_W-1:0]        cnt_inc;
    logic [goc_pkg::CNT_W-1:0]        target;
    logic                             finish;
    logic                             out_free;
    logic                             out_load;
    goc_pkg::lane_ctl_t               ctl;

    goc_pkg::axis_t                   raw_arr  [goc_pkg::NUM_AXES];
    goc_pkg::axis_t                   corr_arr [goc_pkg::NUM_AXES];
    goc_pkg::rate_t                   rate_arr [goc_pkg::NUM_AXES];

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == goc_pkg::ADDR_CALIB);
    assign prdata    = (paddr == goc_pkg::ADDR_CALIB)
                       ? goc_pkg::APB_DW'(calib_samples_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_samples_reg <= goc_pkg::CALIB_RESET;
        end
        else if (cfg_write)
        begin
            calib_samples_reg <= pwdata[goc_pkg::CNT_W-1:0];
        end
    end

    assign samp.ready = (state_reg == goc_pkg::S_IDLE);
    assign accept     = samp.valid && samp.ready;

    assign cnt_inc = count_reg + 1'b1;
    assign target  = (calib_samples_reg == '0) ? goc_pkg::CNT_W'(1) : calib_samples_reg;
    assign finish  = calib_reg && (cnt_inc >= target);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            goc_pkg::S_IDLE:
            begin
                if (samp.valid)
                begin
                    state_next = (goc_pkg::mode_t'(samp.mode) == goc_pkg::MODE_MEAS)
                                 ? goc_pkg::S_MEAS : goc_pkg::S_EXEC;
                end
            end
            goc_pkg::S_MEAS:     state_next = goc_pkg::S_PROD;
            goc_pkg::S_PROD:     state_next = goc_pkg::S_OUT;
            goc_pkg::S_EXEC:
            begin
                state_next = (mode_reg == goc_pkg::MODE_SAMPLE && finish)
                             ? goc_pkg::S_DIV_INIT : goc_pkg::S_SHOW;
            end
            goc_pkg::S_DIV_INIT: state_next = goc_pkg::S_DIV;
            goc_pkg::S_DIV:
            begin
                if (step_reg == goc_pkg::STEP_W'(goc_pkg::DIV_STEPS - 1))
                begin
                    state_next = goc_pkg::S_COMMIT;
                end
            end
            goc_pkg::S_COMMIT:   state_next = goc_pkg::S_SHOW;
            goc_pkg::S_SHOW:     state_next = goc_pkg::S_OUT;
            goc_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    state_next = goc_pkg::S_IDLE;
                end
            end
            default:             state_next = goc_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        ctl         = '0;
        ctl.capture = accept;
        out_load    = 1'b0;
        unique case (state_reg)
            goc_pkg::S_MEAS:     ctl.corr_raw   = 1'b1;
            goc_pkg::S_PROD:     ctl.prod_en    = 1'b1;
            goc_pkg::S_EXEC:
            begin
                ctl.clear = (mode_reg == goc_pkg::MODE_START);
                ctl.accum = (mode_reg == goc_pkg::MODE_SAMPLE) && calib_reg;
                ctl.load  = (mode_reg == goc_pkg::MODE_LOAD);
            end
            goc_pkg::S_DIV_INIT: ctl.div_start  = 1'b1;
            goc_pkg::S_DIV:      ctl.div_step   = 1'b1;
            goc_pkg::S_COMMIT:   ctl.div_commit = 1'b1;
            goc_pkg::S_SHOW:     ctl.corr_off   = 1'b1;
            goc_pkg::S_OUT:      out_load       = out_free;
            default:             out_load       = 1'b0;
        endcase
    end

    // calibration bookkeeping
    always_comb
    begin
        calib_next = calib_reg;
        count_next = count_reg;
        done_next  = done_reg;
        step_next  = step_reg;
        if (accept)
        begin
            done_next = 1'b0;
        end
        unique case (state_reg)
            goc_pkg::S_EXEC:
            begin
                case (mode_reg)
                    goc_pkg::MODE_START:
                    begin
                        count_next = '0;
                        calib_next = 1'b1;
                    end
                    goc_pkg::MODE_SAMPLE:
                    begin
                        if (calib_reg)
                        begin
                            count_next = cnt_inc;
                            done_next  = finish;
                        end
                    end
                    goc_pkg::MODE_LOAD:
                    begin
                        calib_next = 1'b0;
                    end
                    default:
                    begin
                        calib_next = calib_reg;
                    end
                endcase
            end
            goc_pkg::S_DIV_INIT: step_next  = '0;
            goc_pkg::S_DIV:      step_next  = step_reg + 1'b1;
            goc_pkg::S_COMMIT:   calib_next = 1'b0;
            default:             step_next  = step_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= goc_pkg::S_IDLE;
            calib_reg <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            calib_reg <= calib_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= goc_pkg::mode_t'(samp.mode);
        end
    end

    assign raw_arr[0] = samp.raw_x;
    assign raw_arr[1] = samp.raw_y;
    assign raw_arr[2] = samp.raw_z;

    for (genvar g = 0; g < goc_pkg::NUM_AXES; g++)
    begin : g_lane
        goc_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .raw   (raw_arr[g]),
            .count (count_reg),
            .corr  (corr_arr[g]),
            .rate  (rate_arr[g])
        );
    end

    goc_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (out_load),
        .meas  (mode_reg == goc_pkg::MODE_MEAS),
        .done  (done_reg),
        .corr  (corr_arr),
        .rate  (rate_arr),
        .free  (out_free),
        .res   (res)
    );

endmodule

@@ hdl/goc_lane.sv @@
// one axis lane: offset, calibration sum, rate scaling and serial divider
module goc_lane (
    input  logic                              clk,
    input  logic                              rst_n,
    input  goc_pkg::lane_ctl_t                ctl,
    input  goc_pkg::axis_t                    raw,
    input  logic [goc_pkg::CNT_W-1:0]         count,
    output goc_pkg::axis_t                    corr,
    output goc_pkg::rate_t                    rate
);

    goc_pkg::axis_t                    raw_reg;
    goc_pkg::axis_t                    off_reg;
    logic signed [goc_pkg::SUM_W-1:0]  sum_reg;
    goc_pkg::axis_t                    corr_reg;
    logic [goc_pkg::PROD_W-1:0]        prod_reg;
    logic                              neg_reg;
    logic [goc_pkg::SUM_W-1:0]         dq_reg;
    logic [goc_pkg::CNT_W-1:0]         rem_reg;
    logic                              sneg_reg;

    goc_pkg::axis_t                    corr_sum;
    logic [goc_pkg::RAW_W-1:0]         corr_mag;
    logic [goc_pkg::SUM_W-1:0]         sum_mag;
    logic [goc_pkg::CNT_W:0]           rem_sh;
    logic [goc_pkg::CNT_W:0]           rem_sub;
    logic                              fits;
    logic [goc_pkg::RATE_W-1:0]        rate_mag;
    logic [goc_pkg::RAW_W-1:0]         quo_low;
    goc_pkg::axis_t                    off_div;

    function automatic goc_pkg::axis_t corr_t_add(goc_pkg::axis_t a, goc_pkg::axis_t b);
        corr_t_add = a + b;
    endfunction

    always_comb
    begin
        corr_sum = corr_t_add(raw_reg, off_reg);
        corr_mag = corr_reg[goc_pkg::RAW_W-1] ? (~corr_reg + 1'b1) : corr_reg;
        sum_mag  = sum_reg[goc_pkg::SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        // restoring divide: bring in the next dividend bit
        rem_sh   = {rem_reg, dq_reg[goc_pkg::SUM_W-1]};
        fits     = rem_sh >= {1'b0, count};
        rem_sub  = rem_sh - {1'b0, count};
        rate_mag = prod_reg[goc_pkg::RECIP_SHIFT +: goc_pkg::RATE_W];
        rate     = neg_reg ? -$signed(rate_mag) : $signed(rate_mag);
        quo_low  = dq_reg[goc_pkg::RAW_W-1:0];
        // offset is minus the truncated average
        off_div  = sneg_reg ? $signed(quo_low) : -$signed(quo_low);
    end

    assign corr = corr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            if (ctl.clear)
            begin
                off_reg <= '0;
                sum_reg <= '0;
            end
            else if (ctl.accum)
            begin
                sum_reg <= sum_reg + goc_pkg::SUM_W'(raw_reg);
            end
            if (ctl.load)
            begin
                off_reg <= raw_reg;
            end
            else if (ctl.div_commit)
            begin
                off_reg <= off_div;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            raw_reg <= raw;
        end
        if (ctl.corr_raw)
        begin
            corr_reg <= corr_sum;
        end
        else if (ctl.corr_off)
        begin
            corr_reg <= off_reg;
        end
        if (ctl.prod_en)
        begin
            prod_reg <= goc_pkg::PROD_W'(corr_mag) * goc_pkg::PROD_W'(goc_pkg::RATE_RECIP);
            neg_reg  <= corr_reg[goc_pkg::RAW_W-1];
        end
        if (ctl.div_start)
        begin
            dq_reg   <= sum_mag;
            rem_reg  <= '0;
            sneg_reg <= sum_reg[goc_pkg::SUM_W-1];
        end
        else if (ctl.div_step)
        begin
            dq_reg  <= {dq_reg[goc_pkg::SUM_W-2:0], fits};
            rem_reg <= fits ? rem_sub[goc_pkg::CNT_W-1:0] : rem_sh[goc_pkg::CNT_W-1:0];
        end
    end

endmodule

@@ hdl/goc_merge.sv @@
// merges the lane results into the registered result word
module goc_merge (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               meas,
    input  logic               done,
    input  goc_pkg::axis_t     corr [goc_pkg::NUM_AXES],
    input  goc_pkg::rate_t     rate [goc_pkg::NUM_AXES],
    output logic               free,
    goc_out_if.source          res
);

    logic               valid_reg;
    logic               valid_next;
    goc_pkg::axis_t     corr_reg [goc_pkg::NUM_AXES];
    goc_pkg::rate_t     rate_reg [goc_pkg::NUM_AXES];
    logic               done_reg;

    assign free = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < goc_pkg::NUM_AXES; i++)
            begin
                corr_reg[i] <= corr[i];
                // rates only carry meaning on a measurement
                rate_reg[i] <= meas ? rate[i] : '0;
            end
            done_reg <= done;
        end
    end

    assign res.valid      = valid_reg;
    assign res.corr_x     = corr_reg[0];
    assign res.corr_y     = corr_reg[1];
    assign res.corr_z     = corr_reg[2];
    assign res.rate_x     = rate_reg[0];
    assign res.rate_y     = rate_reg[1];
    assign res.rate_z     = rate_reg[2];
    assign res.calib_done = done_reg;

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for gyro_offset_calibrate: directed and random words against a predictor
module testbench;
    import goc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        axis_t corr_x;
        axis_t corr_y;
        axis_t corr_z;
        rate_t rate_x;
        rate_t rate_y;
        rate_t rate_z;
        logic  calib_done;
    } gyro_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    goc_in_if  samp_ch ();
    goc_out_if res_ch ();

    gyro_offset_calibrate dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samp    (samp_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    axis_t                    offsets [NUM_AXES];
    logic signed [SUM_W-1:0]  axis_acc [NUM_AXES];
    logic [CNT_W-1:0]         samples_seen;
    bit                       calib_busy;
    logic [CNT_W-1:0]         calib_len;

    gyro_word_t expected_words [$];
    int  mismatches = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  quiet = 1'b0;

    always #5 clk = ~clk;

    function automatic rate_t rate_of(axis_t c);
        int p;
        int q;
        p = int'(c) * 128;
        q = (p < 0 ? -p : p) / 115;
        return rate_t'(p < 0 ? -q : q);
    endfunction

    function automatic void predict_word(mode_t m, axis_t x, axis_t y, axis_t z);
        axis_t raw [NUM_AXES];
        axis_t corr [NUM_AXES];
        rate_t rate [NUM_AXES];
        logic done;
        logic [CNT_W-1:0] goal;
        longint s;
        longint q;
        gyro_word_t w;
        int i;
        raw[0] = x;
        raw[1] = y;
        raw[2] = z;
        done = 1'b0;
        for (i = 0; i < NUM_AXES; i++)
            rate[i] = '0;
        case (m)
            MODE_MEAS:
                for (i = 0; i < NUM_AXES; i++)
                begin
                    corr[i] = axis_t'(raw[i] + offsets[i]);
                    rate[i] = rate_of(corr[i]);
                end
            MODE_START:
            begin
                for (i = 0; i < NUM_AXES; i++)
                begin
                    offsets[i] = '0;
                    axis_acc[i] = '0;
                end
                samples_seen = '0;
                calib_busy = 1'b1;
            end
            MODE_SAMPLE:
                if (calib_busy)
                begin
                    goal = (calib_len == 0) ? CNT_W'(1) : calib_len;
                    for (i = 0; i < NUM_AXES; i++)
                        axis_acc[i] = axis_acc[i] + raw[i];
                    samples_seen = samples_seen + 1'b1;
                    if (samples_seen >= goal)
                    begin
                        // offset is minus the average, truncated toward zero
                        for (i = 0; i < NUM_AXES; i++)
                        begin
                            s = axis_acc[i];
                            q = (s < 0 ? -s : s) / longint'(samples_seen);
                            offsets[i] = axis_t'(s < 0 ? q : -q);
                        end
                        calib_busy = 1'b0;
                        done = 1'b1;
                    end
                end
            default:
            begin
                for (i = 0; i < NUM_AXES; i++)
                    offsets[i] = raw[i];
                calib_busy = 1'b0;
            end
        endcase
        if (m != MODE_MEAS)
            for (i = 0; i < NUM_AXES; i++)
                corr[i] = offsets[i];
        w.corr_x = corr[0];
        w.corr_y = corr[1];
        w.corr_z = corr[2];
        w.rate_x = rate[0];
        w.rate_y = rate[1];
        w.rate_z = rate[2];
        w.calib_done = done;
        expected_words.push_back(w);
    endfunction

    function automatic axis_t rand_axis();
        case ($urandom_range(7))
            0: return axis_t'(16'h7fff);
            1: return axis_t'(16'h8000);
            2: return axis_t'(0);
            3: return axis_t'(-1);
            default: return axis_t'($urandom);
        endcase
    endfunction

    function automatic axis_t sample_near(axis_t b);
        return axis_t'(int'(b) + int'($urandom_range(200)) - 100);
    endfunction

    task automatic send_word(input mode_t m, input axis_t x, input axis_t y, input axis_t z);
        while (!quiet && $urandom_range(99) < 6)
        begin
            samp_ch.valid <= 1'b0;
            @(posedge clk);
        end
        samp_ch.valid <= 1'b1;
        samp_ch.mode  <= m;
        samp_ch.raw_x <= x;
        samp_ch.raw_y <= y;
        samp_ch.raw_z <= z;
        @(posedge clk);
        while (!samp_ch.ready)
            @(posedge clk);
        predict_word(m, x, y, z);
    endtask

    task automatic drain();
        samp_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_calib_len(input logic [CNT_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CALIB;
        // upper bits are don't care for a 16-bit register
        pwdata  <= {16'($urandom), v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        calib_len = v;
        @(posedge clk);
    endtask

    function automatic void note_mismatch(string what, gyro_word_t want, gyro_word_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s: exp corr %0d %0d %0d rate %0d %0d %0d done %0b",
                what, want.corr_x, want.corr_y, want.corr_z, want.rate_x, want.rate_y,
                want.rate_z, want.calib_done);
            $display("    got corr %0d %0d %0d rate %0d %0d %0d done %0b",
                got.corr_x, got.corr_y, got.corr_z,
                got.rate_x, got.rate_y, got.rate_z, got.calib_done);
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        gyro_word_t want;
        gyro_word_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.corr_x = res_ch.corr_x;
            got.corr_y = res_ch.corr_y;
            got.corr_z = res_ch.corr_z;
            got.rate_x = res_ch.rate_x;
            got.rate_y = res_ch.rate_y;
            got.rate_z = res_ch.rate_z;
            got.calib_done = res_ch.calib_done;
            if (expected_words.size() == 0)
            begin
                want = '0;
                note_mismatch("unexpected word", want, got);
            end
            else
            begin
                want = expected_words.pop_front();
                if (want !== got)
                    note_mismatch("word mismatch", want, got);
            end
        end
    end

    // result receiver with random stalls and a long hold-off on request
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= quiet || $urandom_range(99) >= 6;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic test_measure_and_load();
        send_word(MODE_MEAS, axis_t'(16'h7fff), axis_t'(16'h8000), axis_t'(0));
        send_word(MODE_MEAS, axis_t'(115), axis_t'(-115), axis_t'(1));
        send_word(MODE_MEAS, axis_t'(-1), axis_t'(114), axis_t'(-114));
        send_word(MODE_MEAS, axis_t'(16'h5555), axis_t'(16'haaaa), axis_t'(-32767));
        send_word(MODE_LOAD, axis_t'(16'h7fff), axis_t'(16'h8000), axis_t'(-1));
        // offset addition wraps at 16 bits
        send_word(MODE_MEAS, axis_t'(1), axis_t'(-1), axis_t'(16'h8000));
        send_word(MODE_MEAS, axis_t'(16'h8000), axis_t'(16'h7fff), axis_t'(0));
        // sample while idle is ignored
        send_word(MODE_SAMPLE, axis_t'(1234), axis_t'(-4321), axis_t'(77));
    endtask

    task automatic test_zero_calibration();
        drain();
        write_calib_len(CNT_W'(4));
        send_word(MODE_START, axis_t'(16'h7fff), axis_t'(16'h8000), axis_t'(-1));
        send_word(MODE_SAMPLE, axis_t'(10), axis_t'(-10), axis_t'(7));
        send_word(MODE_SAMPLE, axis_t'(11), axis_t'(-11), axis_t'(-3));
        // measure in the middle of a calibration keeps it pending
        send_word(MODE_MEAS, axis_t'(500), axis_t'(-500), axis_t'(0));
        send_word(MODE_SAMPLE, axis_t'(10), axis_t'(-10), axis_t'(0));
        send_word(MODE_SAMPLE, axis_t'(10), axis_t'(-10), axis_t'(1));
        send_word(MODE_MEAS, axis_t'(10), axis_t'(-10), axis_t'(1));
        drain();
        // zero count behaves as one
        write_calib_len(CNT_W'(0));
        send_word(MODE_START, axis_t'(3), axis_t'(4), axis_t'(5));
        send_word(MODE_SAMPLE, axis_t'(16'h8000), axis_t'(16'h7fff), axis_t'(0));
    endtask

    task automatic test_count_shrink_and_cancel();
        drain();
        write_calib_len(CNT_W'(16'hffff));
        send_word(MODE_START, axis_t'(0), axis_t'(0), axis_t'(0));
        send_word(MODE_SAMPLE, axis_t'(16'h8000), axis_t'(16'h7fff), axis_t'(5));
        send_word(MODE_SAMPLE, axis_t'(16'h8000), axis_t'(16'h7fff), axis_t'(-5));
        send_word(MODE_SAMPLE, axis_t'(-32767), axis_t'(16'h7fff), axis_t'(3));
        drain();
        // count already past the new length, next sample closes the run
        write_calib_len(CNT_W'(2));
        send_word(MODE_SAMPLE, axis_t'(-32767), axis_t'(16'h7fff), axis_t'(-2));
        send_word(MODE_START, axis_t'(9), axis_t'(9), axis_t'(9));
        send_word(MODE_SAMPLE, axis_t'(300), axis_t'(-300), axis_t'(30));
        // load cancels the pending calibration
        send_word(MODE_LOAD, axis_t'(-20), axis_t'(20), axis_t'(16'h8000));
        send_word(MODE_SAMPLE, axis_t'(300), axis_t'(-300), axis_t'(30));
        send_word(MODE_MEAS, axis_t'(20), axis_t'(-20), axis_t'(16'h7fff));
    endtask

    task automatic test_random_traffic(input logic [CNT_W-1:0] len, input int n_items,
                                       input bit no_idle);
        int sent;
        int goal;
        int k;
        int j;
        axis_t bx;
        axis_t by;
        axis_t bz;
        mode_t m;
        drain();
        write_calib_len(len);
        quiet = no_idle;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 70)
            begin
                goal = (len == 0) ? 1 : int'(len);
                bx = rand_axis();
                by = rand_axis();
                bz = rand_axis();
                send_word(MODE_START, rand_axis(), rand_axis(), rand_axis());
                sent++;
                for (k = 0; k < goal; k++)
                begin
                    if ($urandom_range(7) == 0)
                    begin
                        send_word(MODE_MEAS, rand_axis(), rand_axis(), rand_axis());
                        sent++;
                    end
                    if ($urandom_range(24) == 0)
                    begin
                        m = $urandom_range(1) ? MODE_LOAD : MODE_START;
                        send_word(m, rand_axis(), rand_axis(), rand_axis());
                        sent++;
                        break;
                    end
                    send_word(MODE_SAMPLE, sample_near(bx), sample_near(by), sample_near(bz));
                    sent++;
                end
                for (j = $urandom_range(3); j >= 0; j--)
                begin
                    send_word(MODE_MEAS, sample_near(bx), sample_near(by), sample_near(bz));
                    sent++;
                end
            end
            else
            begin
                m = mode_t'($urandom_range(3));
                if (!(m == MODE_SAMPLE && !calib_busy))
                    sent++;
                send_word(m, rand_axis(), rand_axis(), rand_axis());
            end
        end
        quiet = 1'b0;
    endtask

    task automatic test_output_backpressure();
        int k;
        drain();
        hold_left = 400;
        for (k = 0; k < 40; k++)
            send_word(mode_t'($urandom_range(3)), rand_axis(), rand_axis(), rand_axis());
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        samp_ch.valid = 1'b0;
        samp_ch.mode = MODE_MEAS;
        samp_ch.raw_x = '0;
        samp_ch.raw_y = '0;
        samp_ch.raw_z = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            offsets[i] = '0;
            axis_acc[i] = '0;
        end
        samples_seen = '0;
        calib_busy = 1'b0;
        calib_len = CALIB_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_measure_and_load();
        test_zero_calibration();
        test_count_shrink_and_cancel();
        test_random_traffic(CNT_W'(1), 130, 1'b0);
        test_random_traffic(CNT_W'(3), 130, 1'b1);
        test_random_traffic(CNT_W'(0), 130, 1'b0);
        test_output_backpressure();
        test_random_traffic(CNT_W'(8), 130, 1'b0);
        test_random_traffic(CNT_W'($urandom_range(6, 2)), 130, 1'b0);
        drain();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
